@@ rtl/first_fit_allocator_coalescing_assert.svh @@
// Assertion macros for the allocator RTL.
`ifndef FIRST_FIT_ALLOCATOR_COALESCING_ASSERT_SVH
`define FIRST_FIT_ALLOCATOR_COALESCING_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define FFA_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define FFA_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FFA_ASSERT_IMP(name, clk, rstn, ante, cons, msg)
`define FFA_ASSERT_NXT(name, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/ffa_pkg.sv @@
package ffa_pkg;

  localparam int unsigned FFA_HEAP_BYTES   = 1024;
  localparam int unsigned FFA_MAX_SEGMENTS = 1024;

  localparam int unsigned SIZE_W = 11;
  localparam int unsigned ADDR_W = 32;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_ALREADY = 2'd2,
    ST_OUTSIDE = 2'd3
  } ffa_status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } ffa_op_e;

endpackage

@@ rtl/first_fit_allocator_coalescing.sv @@
// First-fit heap allocator with coalescing. The heap is an address-ordered
// chain of segments kept in a single-port-read, single-port-write segment
// memory (one entry per slot), plus a stack memory of recycled slots. A
// request walks the chain one segment per cycle, since the read data of one
// entry supplies the address of the next. After the walk (at most
// MAX_SEGMENTS segments visited), an allocate ends at once on no fit,
// writes the segment on an exact fit, and on a split writes the remainder
// into a new slot and then the segment, first popping a recycled slot when
// the stack holds one; a free ends at once when already free or not found,
// merges at once on the last segment of the chain, otherwise first reads the
// next segment, and pushes a second freed slot when it merges on both sides.
// Early rejects (zero size, size above free bytes, address outside the heap)
// skip the walk. The input is ready again in the cycle after the result is
// loaded. A new item is accepted while the previous result still waits at
// the output register; its own result is held back until that beat is taken.
// heap_base is written on the cfg channel and must only change while idle.
// After reset the whole heap is one free segment; no clearing pass is run.
`include "first_fit_allocator_coalescing_assert.svh"

module first_fit_allocator_coalescing import ffa_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = FFA_HEAP_BYTES,
  parameter int unsigned MAX_SEGMENTS = FFA_MAX_SEGMENTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ADDR_W-1:0] cfg_data_i,
  // request
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [SIZE_W-1:0] req_size_i,
  input  logic [ADDR_W-1:0] address_i,
  // result
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] block_address_o,
  output logic [1:0]        status_o
);

  localparam int unsigned OW = $clog2(HEAP_BYTES);      // offset
  localparam int unsigned SW = $clog2(HEAP_BYTES + 1);  // size
  localparam int unsigned IW = $clog2(MAX_SEGMENTS);    // slot index
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);// slot count

  typedef struct packed {
    logic [OW-1:0] off;
    logic [SW-1:0] size;
    logic          free;
    logic [IW-1:0] nxt;
    logic          hn;
  } seg_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_WALK = 9'b000000010,
    S_POP  = 9'b000000100,
    S_WNS  = 9'b000001000,
    S_WCUR = 9'b000010000,
    S_NXRD = 9'b000100000,
    S_MRG  = 9'b001000000,
    S_PSH2 = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  // memories
  seg_t          seg_mem [MAX_SEGMENTS];
  logic [IW-1:0] stk_mem [MAX_SEGMENTS];

  state_e        state_q, state_d;
  logic [ADDR_W-1:0] heap_base_q;
  logic [SW-1:0] rem_q, rem_d;
  logic [CW-1:0] stk_cnt_q, stk_cnt_d;
  logic [CW-1:0] fresh_q, fresh_d;
  logic          virgin_q;

  logic          op_q;
  logic [SIZE_W-1:0] size_q;
  logic [OW-1:0] off_q;
  logic [IW-1:0] cur_q, prev_q, ns_q;
  seg_t          cur_e_q, prev_e_q, nx_e_q;
  logic          has_prev_q, nx_vld_q, split_q;
  logic [ADDR_W-1:0] res_addr_q;
  ffa_status_e   res_st_q;

  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  ffa_status_e       out_st_q;

  // memory ports
  logic [IW-1:0] seg_raddr, rd_addr_q;
  seg_t          seg_rd_q, seg_rd;
  logic          seg_we;
  logic [IW-1:0] seg_waddr;
  seg_t          seg_wdata;
  logic [IW-1:0] stk_rd_q;
  logic          stk_we;
  logic [IW-1:0] stk_wdata;
  logic [CW-1:0] stk_top;

  // next-cycle captures
  logic          op_d, has_prev_d, nx_vld_d, split_d;
  logic [SIZE_W-1:0] size_d;
  logic [OW-1:0] off_d;
  logic [IW-1:0] cur_d, prev_d, ns_d;
  seg_t          cur_e_d, prev_e_d, nx_e_d;
  logic [ADDR_W-1:0] res_addr_d;
  ffa_status_e   res_st_d;

  // helpers
  logic [ADDR_W-1:0] off32;
  logic          hit, contains;
  logic [OW-1:0] diff;
  logic          nxm, pm;
  seg_t          c2;
  logic          out_free;
  logic          out_fail, in_fire;

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign block_address_o = out_addr_q;
  assign status_o        = out_st_q;
  assign out_free        = !out_valid_q || out_ready_i;
  assign out_fail        = out_valid_o && (status_o != ST_DONE);
  assign in_fire         = in_valid_i && in_ready_o;

  // slot 0 reads as the whole free heap until first written
  always_comb begin
    seg_rd = seg_rd_q;
    if (virgin_q && (rd_addr_q == '0)) begin
      seg_rd      = '0;
      seg_rd.size = SW'(HEAP_BYTES);
      seg_rd.free = 1'b1;
    end
  end

  assign off32    = address_i - heap_base_q;
  assign hit      = seg_rd.free && (32'(seg_rd.size) >= 32'(size_q));
  assign diff     = off_q - seg_rd.off;
  assign contains = (off_q >= seg_rd.off) && (SW'(diff) < seg_rd.size);
  assign stk_top  = stk_cnt_q - CW'(1);

  // merge terms for a free
  assign nxm = nx_vld_q && nx_e_q.free;
  assign pm  = has_prev_q && prev_e_q.free;
  always_comb begin
    c2      = cur_e_q;
    c2.free = 1'b1;
    if (nxm) begin
      c2.size = cur_e_q.size + nx_e_q.size;
      c2.nxt  = nx_e_q.nxt;
      c2.hn   = nx_e_q.hn;
    end
  end

  always_comb begin
    state_d    = state_q;
    rem_d      = rem_q;
    stk_cnt_d  = stk_cnt_q;
    fresh_d    = fresh_q;
    op_d       = op_q;
    size_d     = size_q;
    off_d      = off_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    ns_d       = ns_q;
    cur_e_d    = cur_e_q;
    prev_e_d   = prev_e_q;
    nx_e_d     = nx_e_q;
    has_prev_d = has_prev_q;
    nx_vld_d   = nx_vld_q;
    split_d    = split_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    seg_raddr  = '0;
    seg_we     = 1'b0;
    seg_waddr  = cur_q;
    seg_wdata  = cur_e_q;
    stk_we     = 1'b0;
    stk_wdata  = cur_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = op_i;
          size_d     = req_size_i;
          off_d      = off32[OW-1:0];
          has_prev_d = 1'b0;
          res_addr_d = '0;
          if (op_i == OP_ALLOC) begin
            if ((req_size_i == '0) || (32'(req_size_i) > 32'(rem_q))) begin
              res_st_d = ST_NOFIT;
              state_d  = S_DONE;
            end else begin
              state_d = S_WALK;
            end
          end else if (off32 >= 32'(HEAP_BYTES)) begin
            res_st_d = ST_OUTSIDE;
            state_d  = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        cur_d   = rd_addr_q;
        cur_e_d = seg_rd;
        if (op_q == OP_ALLOC) begin
          if (hit) begin
            split_d = (seg_rd.size != SW'(size_q));
            if (seg_rd.size == SW'(size_q)) begin
              state_d = S_WCUR;
            end else if (stk_cnt_q != '0) begin
              state_d = S_POP;
            end else if (fresh_q < CW'(MAX_SEGMENTS)) begin
              ns_d    = fresh_q[IW-1:0];
              fresh_d = fresh_q + CW'(1);
              state_d = S_WNS;
            end else begin
              res_st_d = ST_NOFIT;
              state_d  = S_DONE;
            end
          end else if (!seg_rd.hn) begin
            res_st_d = ST_NOFIT;
            state_d  = S_DONE;
          end else begin
            seg_raddr = seg_rd.nxt;
          end
        end else begin
          if (contains) begin
            if (seg_rd.free) begin
              res_st_d = ST_ALREADY;
              state_d  = S_DONE;
            end else if (seg_rd.hn) begin
              seg_raddr = seg_rd.nxt;
              state_d   = S_NXRD;
            end else begin
              nx_vld_d = 1'b0;
              state_d  = S_MRG;
            end
          end else if (!seg_rd.hn) begin
            res_st_d = ST_OUTSIDE;
            state_d  = S_DONE;
          end else begin
            prev_d     = rd_addr_q;
            prev_e_d   = seg_rd;
            has_prev_d = 1'b1;
            seg_raddr  = seg_rd.nxt;
          end
        end
      end
      S_POP: begin
        ns_d      = stk_rd_q;
        stk_cnt_d = stk_top;
        state_d   = S_WNS;
      end
      S_WNS: begin
        seg_we         = 1'b1;
        seg_waddr      = ns_q;
        seg_wdata.off  = cur_e_q.off + OW'(size_q);
        seg_wdata.size = cur_e_q.size - SW'(size_q);
        seg_wdata.free = 1'b1;
        seg_wdata.nxt  = cur_e_q.nxt;
        seg_wdata.hn   = cur_e_q.hn;
        state_d        = S_WCUR;
      end
      S_WCUR: begin
        seg_we         = 1'b1;
        seg_waddr      = cur_q;
        seg_wdata.off  = cur_e_q.off;
        seg_wdata.size = SW'(size_q);
        seg_wdata.free = 1'b0;
        seg_wdata.nxt  = split_q ? ns_q : cur_e_q.nxt;
        seg_wdata.hn   = split_q ? 1'b1 : cur_e_q.hn;
        rem_d          = rem_q - SW'(size_q);
        res_addr_d     = heap_base_q + ADDR_W'(cur_e_q.off);
        res_st_d       = ST_DONE;
        state_d        = S_DONE;
      end
      S_NXRD: begin
        nx_e_d   = seg_rd;
        nx_vld_d = 1'b1;
        state_d  = S_MRG;
      end
      S_MRG: begin
        seg_we = 1'b1;
        if (pm) begin
          seg_waddr      = prev_q;
          seg_wdata      = prev_e_q;
          seg_wdata.size = prev_e_q.size + c2.size;
          seg_wdata.nxt  = c2.nxt;
          seg_wdata.hn   = c2.hn;
        end else begin
          seg_waddr = cur_q;
          seg_wdata = c2;
        end
        rem_d    = rem_q + cur_e_q.size;
        res_st_d = ST_DONE;
        state_d  = S_DONE;
        if (nxm) begin
          stk_we    = 1'b1;
          stk_wdata = cur_e_q.nxt;
          stk_cnt_d = stk_cnt_q + CW'(1);
          if (pm) begin
            state_d = S_PSH2;
          end
        end else if (pm) begin
          stk_we    = 1'b1;
          stk_wdata = cur_q;
          stk_cnt_d = stk_cnt_q + CW'(1);
        end
      end
      S_PSH2: begin
        stk_we    = 1'b1;
        stk_wdata = cur_q;
        stk_cnt_d = stk_cnt_q + CW'(1);
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // segment memory: one read, one write, registered read data
  always_ff @(posedge clk_i) begin
    if (seg_we) begin
      seg_mem[seg_waddr] <= seg_wdata;
    end
    seg_rd_q  <= seg_mem[seg_raddr];
    rd_addr_q <= seg_raddr;
  end

  // recycled slot stack
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_cnt_q[IW-1:0]] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_top[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heap_base_q <= '0;
      rem_q       <= SW'(HEAP_BYTES);
      stk_cnt_q   <= '0;
      fresh_q     <= CW'(1);
      virgin_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rem_q     <= rem_d;
      stk_cnt_q <= stk_cnt_d;
      fresh_q   <= fresh_d;
      if (cfg_valid_i) begin
        heap_base_q <= cfg_data_i;
      end
      if (seg_we && (seg_waddr == '0)) begin
        virgin_q <= 1'b0;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    size_q     <= size_d;
    off_q      <= off_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    ns_q       <= ns_d;
    cur_e_q    <= cur_e_d;
    prev_e_q   <= prev_e_d;
    nx_e_q     <= nx_e_d;
    has_prev_q <= has_prev_d;
    nx_vld_q   <= nx_vld_d;
    split_q    <= split_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    if ((state_q == S_DONE) && out_free) begin
      out_addr_q <= res_addr_q;
      out_st_q   <= res_st_q;
    end
  end

  `FFA_ASSERT_IMP(a_stk_bound, clk_i, rst_ni, 1'b1, stk_cnt_q < fresh_q, "slot stack overflow")
  `FFA_ASSERT_IMP(a_rem_bound, clk_i, rst_ni, 1'b1, rem_q <= SW'(HEAP_BYTES), "rem above heap")
  `FFA_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, out_fail, block_address_o == '0, "fail with address")
  `FFA_ASSERT_NXT(a_walk_idle, clk_i, rst_ni, in_fire, state_q != S_IDLE, "item not started")

endmodule
